// ----- hdl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg: shared types for the sorted priority queue
// Entry layout, the per-cycle control word sent to every cell, and the
// status codes returned with each result word.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int KEY_W    = 8;
	localparam int TAG_W    = 8;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t new_entry;
	} cell_ctl_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_POP    = 1'b1;

endpackage

// ----- hdl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Holds one entry. On insert it holds, takes its left neighbor's entry, or
// takes the new entry; on pop it takes its right neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      valid,
	input  logic      left_place,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	output entry_t    entry,
	output logic      place
);

	entry_t entry_q;

	// slot is free or its entry must move right to make room
	assign place = !valid || (entry_q.key < ctl.new_entry.key);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			entry_q <= right_entry;
		end else if (ctl.ins && place) begin
			// left neighbor also moves: follow it; otherwise the new entry lands here
			if (left_place) begin
				entry_q <= left_entry;
			end else begin
				entry_q <= ctl.new_entry;
			end
		end
	end

endmodule

// ----- hdl/sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_core: bounded priority queue in a chain of cells
// Entries are kept in descending key order, equal keys first in, first out.
//
//   channel | dir | tdata                       | tuser
//   s_      | in  | entry_key, entry_tag        | mode
//   m_      | out | out_key, out_tag, occupancy | out_valid, status
//
// One word per cycle while the output is not stalled: every cell compares its key
// with the new key in the same cycle and moves at most one slot.
// The result register frees the input whenever the output is taken or empty.
// Reset empties the queue at once (count to zero); cell contents are not reset.
// A stalled output holds its word and stops input acceptance.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] entry_key, [15:8] entry_tag
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_key, [15:8] out_tag, [20:16] occupancy
	output logic [2:0]  m_tuser    // [0] out_valid, [2:1] status
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic             in_acc;
	logic             is_full;
	logic             is_empty;
	cell_ctl_t        ctl;
	entry_t           entries [QUEUE_DEPTH];
	logic             places  [QUEUE_DEPTH];

	logic             m_tvalid_q;
	logic             res_valid_q;
	logic [KEY_W-1:0] res_key_q;
	logic [TAG_W-1:0] res_tag_q;
	status_t          res_status_q;
	logic [OCC_W-1:0] res_occ_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign in_acc   = s_tvalid && s_tready;
	assign is_full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	always_comb begin
		ctl.new_entry.key = s_tdata[7:0];
		ctl.new_entry.tag = s_tdata[15:8];
		ctl.ins = in_acc && (s_tuser == MODE_INSERT) && !is_full;
		ctl.pop = in_acc && (s_tuser == MODE_POP) && !is_empty;
		count_next = count_q;
		if (ctl.ins) begin
			count_next = count_q + CNT_W'(1);
		end else if (ctl.pop) begin
			count_next = count_q - CNT_W'(1);
		end
	end

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic   left_place;
		entry_t left_entry;
		entry_t right_entry;

		if (i == 0) begin : g_head
			assign left_place = 1'b0;
			assign left_entry = '0;
		end else begin : g_mid
			assign left_place = places[i-1];
			assign left_entry = entries[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign right_entry = '0;
		end else begin : g_body
			assign right_entry = entries[i+1];
		end

		spq_cell u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.valid       (count_q > CNT_W'(i)),
			.left_place  (left_place),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entries[i]),
			.place       (places[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (in_acc) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_valid_q <= ctl.pop;
			res_key_q   <= ctl.pop ? entries[0].key : '0;
			res_tag_q   <= ctl.pop ? entries[0].tag : '0;
			res_occ_q   <= OCC_W'(count_next);
			if (s_tuser == MODE_POP) begin
				res_status_q <= is_empty ? ST_EMPTY : ST_OK;
			end else begin
				res_status_q <= is_full ? ST_FULL : ST_OK;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {3'b000, res_occ_q, res_tag_q, res_key_q};
	assign m_tuser  = {res_status_q, res_valid_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above depth");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(count_q))
		else $error("entry count moved without an accepted word");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> m_tvalid)
		else $error("accepted word produced no result");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q > CNT_W'(1)) |-> (entries[0].key >= entries[1].key))
		else $error("head entries out of key order");

endmodule

// ----- test/sorted_priority_queue_core_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_tb: self-checking bench for the sorted queue
// Drives insert and pop words with random gaps and output stalls, and keeps
// its own copy of the queue to predict each result word. Results are compared
// field by field, in order, as they leave the block.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_tb import spq_pkg::*; ();

	localparam int DEPTH        = 16;
	localparam int RANDOM_WORDS = 730;
	localparam int CALM_WORDS   = 150;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic             out_valid;
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} pop_word_t;

	class spq_scoreboard;
		entry_t    held[$];
		pop_word_t due[$];
		int        errors;
		int        inserts;
		int        pops;
		int        empty_pops;
		int        full_drops;
		int        peak;

		function new();
			errors     = 0;
			inserts    = 0;
			pops       = 0;
			empty_pops = 0;
			full_drops = 0;
			peak       = 0;
		endfunction

		// Update the queue copy and queue up the result this word must produce.
		function void note_word(logic mode, entry_t e);
			pop_word_t r;
			entry_t    head;
			int        pos;
			r.out_valid = 1'b0;
			r.key       = '0;
			r.tag       = '0;
			r.status    = ST_OK;
			if (mode == MODE_POP) begin
				if (held.size() == 0) begin
					r.status = ST_EMPTY;
					empty_pops++;
				end else begin
					head        = held.pop_front();
					r.out_valid = 1'b1;
					r.key       = head.key;
					r.tag       = head.tag;
					pops++;
				end
			end else if (held.size() >= DEPTH) begin
				r.status = ST_FULL;
				full_drops++;
			end else begin
				// skip every entry with a key at least as high: equal keys stay in order
				pos = 0;
				while (pos < held.size() && e.key <= held[pos].key)
					pos++;
				held.insert(pos, e);
				inserts++;
				if (held.size() > peak)
					peak = held.size();
			end
			r.occupancy = OCC_W'(held.size());
			due.push_back(r);
		endfunction

		task report(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_word(pop_word_t got);
			pop_word_t want;
			if (due.size() == 0) begin
				report($sformatf("result word with nothing pending (key %0h tag %0h)",
					got.key, got.tag));
			end else begin
				want = due.pop_front();
				if (got.out_valid !== want.out_valid)
					report($sformatf("out_valid %b, expected %b", got.out_valid, want.out_valid));
				if (got.key !== want.key)
					report($sformatf("out_key %0h, expected %0h", got.key, want.key));
				if (got.tag !== want.tag)
					report($sformatf("out_tag %0h, expected %0h", got.tag, want.tag));
				if (got.status !== want.status)
					report($sformatf("status %0d, expected %0d", got.status, want.status));
				if (got.occupancy !== want.occupancy)
					report($sformatf("occupancy %0d, expected %0d", got.occupancy,
						want.occupancy));
			end
		endtask

		function int pending();
			return due.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;

	spq_scoreboard sb;
	logic          calm;
	int            quiet;
	int            words_sent;

	sorted_priority_queue_core #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Monitor both channels and run the stall watchdog.
	always @(posedge clk) begin
		pop_word_t got;
		entry_t    e;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				e.key = s_tdata[7:0];
				e.tag = s_tdata[15:8];
				sb.note_word(s_tuser, e);
			end
			if (m_tvalid && m_tready) begin
				got.key       = m_tdata[7:0];
				got.tag       = m_tdata[15:8];
				got.occupancy = m_tdata[20:16];
				got.out_valid = m_tuser[0];
				got.status    = status_t'(m_tuser[2:1]);
				sb.check_word(got);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Output side: random ready and stall bursts, always ready once calm.
	initial begin
		int n;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (calm) begin
				m_tready <= 1'b1;
				@(negedge clk);
			end else begin
				n = $urandom_range(1, 17);
				m_tready <= ($urandom_range(0, 2) != 0);
				repeat (n) @(negedge clk);
			end
		end
	end

	// Present one word at a falling edge and hold it until taken.
	task push_word(logic mode, logic [7:0] key, logic [7:0] tag);
		if (!calm && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {tag, key};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		words_sent++;
	endtask

	initial begin
		int         left;
		int         seg;
		int         ins_pct;
		int         key_style;
		int         i;
		logic [7:0] base;
		logic [7:0] key;
		logic       mode;

		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = 1'b0;
		calm       = 1'b0;
		quiet      = 0;
		words_sent = 0;
		sb         = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty pop, key extremes, equal keys, fill, overflow, drain order
		push_word(MODE_POP, 8'h00, 8'h00);
		push_word(MODE_INSERT, 8'h00, 8'hFF);
		push_word(MODE_INSERT, 8'hFF, 8'h00);
		push_word(MODE_INSERT, 8'h80, 8'h11);
		push_word(MODE_INSERT, 8'h80, 8'h22);
		push_word(MODE_INSERT, 8'h80, 8'h33);
		push_word(MODE_POP, 8'h00, 8'h00);
		push_word(MODE_INSERT, 8'hFF, 8'hA5);
		for (i = 0; i < DEPTH - 5; i++)
			push_word(MODE_INSERT, 8'(8'h17 * i), 8'(8'h40 + i));
		push_word(MODE_INSERT, 8'hFF, 8'h5A);
		push_word(MODE_INSERT, 8'h00, 8'hC3);
		push_word(MODE_POP, 8'h00, 8'h00);
		push_word(MODE_POP, 8'h00, 8'h00);
		push_word(MODE_POP, 8'h00, 8'h00);

		// random segments, each with its own insert rate and key spread
		left = RANDOM_WORDS;
		while (left > 0) begin
			seg = $urandom_range(30, 80);
			if (seg > left)
				seg = left;
			case ($urandom_range(0, 2))
				0: begin
					ins_pct = 20;
				end
				1: begin
					ins_pct = 50;
				end
				default: begin
					ins_pct = 85;
				end
			endcase
			key_style = $urandom_range(0, 2);
			base      = 8'($urandom_range(0, 252));
			for (i = 0; i < seg; i++) begin
				if (left <= CALM_WORDS)
					calm = 1'b1;
				mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_POP;
				case (key_style)
					0: begin
						key = 8'($urandom_range(0, 255));
					end
					1: begin
						// crowd keys together so ties are common
						key = base + 8'($urandom_range(0, 3));
					end
					default: begin
						key = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					end
				endcase
				push_word(mode, key, 8'($urandom_range(0, 255)));
				left--;
			end
		end

		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words: %0d inserts, %0d pops, %0d empty pops, %0d full drops",
			words_sent, sb.inserts, sb.pops, sb.empty_pops, sb.full_drops);
		$display("Peak occupancy %0d of %0d, %0d mismatches", sb.peak, DEPTH, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
